// ===== sv/srsm_pkg.sv =====
package srsm_pkg;

	localparam int ENTRY_CAPACITY_D = 1024;
	localparam int MAX_ROWS_D = 256;
	localparam int MAX_COLUMNS_D = 1024;
	localparam int VALUE_WIDTH_D = 32;

	localparam int OP_W = 3;
	localparam int ROW_W = 8;
	localparam int COL_W = 10;
	localparam int DATA_W = 32;
	localparam int STATUS_W = 3;
	localparam int COUNT_W = 11;
	localparam int ROWCFG_W = 9;
	localparam int COLCFG_W = 11;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 11;

	localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD = 3'd1;
	localparam logic [OP_W-1:0] OP_MUL = 3'd2;
	localparam logic [OP_W-1:0] OP_MAX = 3'd3;
	localparam logic [OP_W-1:0] OP_MIN = 3'd4;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;

	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_MERGED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RANGE = 3'd4;
	localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd1;

endpackage

// ===== sv/srsm_merge.sv =====
// Merge of a stored value with a new value; the result of every operation is registered.
module srsm_merge #(
	parameter int VALUE_WIDTH = srsm_pkg::VALUE_WIDTH_D
) (
	input  logic                         clk,
	input  logic [srsm_pkg::OP_W-1:0]    op,
	input  logic [VALUE_WIDTH-1:0]       old_value,
	input  logic [VALUE_WIDTH-1:0]       new_value,
	output logic [VALUE_WIDTH-1:0]       merged_q
);

	logic [VALUE_WIDTH-1:0] merged_d;

	always_comb begin
		merged_d = old_value;
		unique case (op)
			srsm_pkg::OP_ADD: merged_d = old_value + new_value;
			srsm_pkg::OP_MUL: merged_d = VALUE_WIDTH'(old_value * new_value);
			srsm_pkg::OP_MAX: merged_d = ($signed(old_value) < $signed(new_value)) ?
				new_value : old_value;
			srsm_pkg::OP_MIN: merged_d = ($signed(new_value) < $signed(old_value)) ?
				new_value : old_value;
			default: merged_d = old_value;
		endcase
	end

	// Result registered so the multiplier ends at a flop.
	always_ff @(posedge clk) begin
		merged_q <= merged_d;
	end

endmodule

// ===== sv/sparse_row_sorted_merge_store_unit.sv =====
// Sequence: a range error or a clear is answered from the idle state, and a clear then
// reruns the pointer clearing pass; other items read row pointers and scan the row.
// A duplicate or full answer comes after the scan and a merge adds a merge and a write-back
// step; an insert shifts later entries, writes the new entry and raises later row pointers.
// Throughput: one item at a time; an item is taken only in idle with no result waiting.
// Reset: asynchronous, active low; a pass that clears row pointers 0 to MAX_ROWS follows.
module sparse_row_sorted_merge_store_unit #(
	parameter int ENTRY_CAPACITY = srsm_pkg::ENTRY_CAPACITY_D,
	parameter int MAX_ROWS = srsm_pkg::MAX_ROWS_D,
	parameter int MAX_COLUMNS = srsm_pkg::MAX_COLUMNS_D,
	parameter int VALUE_WIDTH = srsm_pkg::VALUE_WIDTH_D
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [srsm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [srsm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [srsm_pkg::OP_W-1:0]         operation,
	input  logic [srsm_pkg::ROW_W-1:0]        row_index,
	input  logic [srsm_pkg::COL_W-1:0]        column_index,
	input  logic signed [srsm_pkg::DATA_W-1:0] element_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [srsm_pkg::STATUS_W-1:0]     status,
	output logic signed [srsm_pkg::DATA_W-1:0] value_now,
	output logic [srsm_pkg::COUNT_W-1:0]      entry_count
);

	localparam int AW = $clog2(ENTRY_CAPACITY);
	localparam int PW = $clog2(ENTRY_CAPACITY + 1);
	localparam int RW = $clog2(MAX_ROWS + 1);
	localparam int CW = $clog2(MAX_COLUMNS);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_RD_LO, S_RD_HI, S_HI, S_SCAN, S_CMP, S_MERGE, S_MWB,
		S_SHIFT_RD, S_SHIFT_WR, S_PUT, S_PTR_RD, S_PTR_WR, S_DONE
	} state_t;

	// Entry memory (column and value per entry) and the row pointer memory.
	logic [CW-1:0]          col_mem [ENTRY_CAPACITY];
	logic [VALUE_WIDTH-1:0] val_mem [ENTRY_CAPACITY];
	logic [PW-1:0]          ptr_mem [MAX_ROWS+1];

	logic [CW-1:0]          col_rd_q;
	logic [VALUE_WIDTH-1:0] val_rd_q;
	logic [PW-1:0]          ptr_rd_q;

	logic                   e_we, p_we;
	logic [AW-1:0]          e_addr, e_waddr;
	logic [CW-1:0]          e_wcol;
	logic [VALUE_WIDTH-1:0] e_wval;
	logic [RW-1:0]          p_addr;
	logic [PW-1:0]          p_wdata;

	state_t                 state_q;
	logic [srsm_pkg::ROWCFG_W-1:0] rows_q;
	logic [srsm_pkg::COLCFG_W-1:0] cols_q;
	logic [PW-1:0]          count_q;
	logic [srsm_pkg::OP_W-1:0] op_q;
	logic [RW-1:0]          row_q;
	logic [CW-1:0]          col_q;
	logic [VALUE_WIDTH-1:0] nv_q;
	logic [PW-1:0]          pos_q, hi_q, k_q;
	logic [RW-1:0]          rp_q;
	logic                   ovalid_q;
	logic [srsm_pkg::STATUS_W-1:0] status_q;
	logic [VALUE_WIDTH-1:0] vnow_q;
	logic [VALUE_WIDTH-1:0] merged_q;

	logic                   accept;
	logic                   in_range;
	logic [PW-1:0]          pos_next;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE) || ovalid_q;
	assign pos_next = pos_q + PW'(1);

	// Saturated register compares against the parameters.
	always_comb begin
		logic [16:0] rlim, clim;
		rlim = (32'(rows_q) > MAX_ROWS) ? 17'(MAX_ROWS) : 17'(rows_q);
		clim = (32'(cols_q) > MAX_COLUMNS) ? 17'(MAX_COLUMNS) : 17'(cols_q);
		in_range = (operation <= srsm_pkg::OP_CLEAR) && (17'(row_index) < rlim) &&
			(17'(column_index) < clim);
	end

	// Memory port drive from the sequencer.
	always_comb begin
		e_we = 1'b0;
		e_addr = pos_q[AW-1:0];
		e_waddr = pos_q[AW-1:0];
		e_wcol = col_q;
		e_wval = nv_q;
		p_we = 1'b0;
		p_addr = row_q;
		p_wdata = '0;
		unique case (state_q)
			S_CLR: begin
				p_we = 1'b1;
				p_addr = rp_q;
			end
			S_RD_HI: p_addr = row_q + RW'(1);
			S_MWB: begin
				e_we = 1'b1;
				e_wcol = col_q;
				e_wval = merged_q;
			end
			S_SHIFT_RD: e_addr = AW'(k_q - PW'(1));
			S_SHIFT_WR: begin
				e_we = 1'b1;
				e_waddr = k_q[AW-1:0];
				e_wcol = col_rd_q;
				e_wval = val_rd_q;
			end
			S_PUT: e_we = 1'b1;
			S_PTR_RD: p_addr = rp_q;
			S_PTR_WR: begin
				p_we = 1'b1;
				p_addr = rp_q;
				p_wdata = ptr_rd_q + PW'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (e_we) begin
			col_mem[e_waddr] <= e_wcol;
			val_mem[e_waddr] <= e_wval;
		end
		col_rd_q <= col_mem[e_addr];
		val_rd_q <= val_mem[e_addr];
		if (p_we) begin
			ptr_mem[p_addr] <= p_wdata;
		end
		ptr_rd_q <= ptr_mem[p_addr];
	end

	srsm_merge #(.VALUE_WIDTH(VALUE_WIDTH)) u_merge (
		.clk(clk), .op(op_q), .old_value(val_rd_q), .new_value(nv_q), .merged_q(merged_q)
	);

	// Sequencer with registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			rows_q <= srsm_pkg::ROWCFG_W'(256);
			cols_q <= srsm_pkg::COLCFG_W'(1024);
			count_q <= '0;
			rp_q <= '0;
			ovalid_q <= 1'b0;
			status_q <= srsm_pkg::ST_RANGE;
			vnow_q <= '0;
			op_q <= '0; row_q <= '0; col_q <= '0; nv_q <= '0;
			pos_q <= '0; hi_q <= '0; k_q <= '0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					srsm_pkg::REG_ROW_COUNT: rows_q <= cfg_data[srsm_pkg::ROWCFG_W-1:0];
					srsm_pkg::REG_COLUMN_COUNT: cols_q <= cfg_data;
					default: ;
				endcase
			end
			if (ovalid_q && !out_stall) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					if (32'(rp_q) == MAX_ROWS) begin
						rp_q <= '0;
						state_q <= S_IDLE;
					end else begin
						rp_q <= rp_q + RW'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q <= operation;
						row_q <= RW'(row_index);
						col_q <= CW'(column_index);
						nv_q <= VALUE_WIDTH'(element_value);
						vnow_q <= '0;
						if (operation == srsm_pkg::OP_CLEAR) begin
							count_q <= '0;
							status_q <= srsm_pkg::ST_CLEARED;
							ovalid_q <= 1'b1;
							rp_q <= '0;
							state_q <= S_CLR;
						end else if (!in_range) begin
							status_q <= srsm_pkg::ST_RANGE;
							ovalid_q <= 1'b1;
						end else begin
							state_q <= S_RD_LO;
						end
					end
				end
				S_RD_LO: state_q <= S_RD_HI;
				S_RD_HI: begin
					pos_q <= ptr_rd_q;
					state_q <= S_HI;
				end
				S_HI: begin
					hi_q <= ptr_rd_q;
					state_q <= S_SCAN;
				end
				// Scan reads pos_q; compare on the next cycle.
				S_SCAN: state_q <= S_CMP;
				S_CMP: begin
					if (pos_q < hi_q && 32'(pos_q) < ENTRY_CAPACITY && col_rd_q < col_q) begin
						pos_q <= pos_next;
						state_q <= S_SCAN;
					end else if (pos_q < hi_q && 32'(pos_q) < ENTRY_CAPACITY &&
						col_rd_q == col_q) begin
						if (op_q == srsm_pkg::OP_INSERT) begin
							status_q <= srsm_pkg::ST_DUPLICATE;
							vnow_q <= val_rd_q;
							ovalid_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_MERGE;
						end
					end else if (32'(count_q) >= ENTRY_CAPACITY) begin
						status_q <= srsm_pkg::ST_FULL;
						ovalid_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						k_q <= count_q;
						state_q <= (count_q > pos_q) ? S_SHIFT_RD : S_PUT;
					end
				end
				S_MERGE: state_q <= S_MWB;
				S_MWB: begin
					status_q <= srsm_pkg::ST_MERGED;
					vnow_q <= merged_q;
					ovalid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SHIFT_RD: state_q <= S_SHIFT_WR;
				S_SHIFT_WR: begin
					k_q <= k_q - PW'(1);
					state_q <= (k_q - PW'(1) > pos_q) ? S_SHIFT_RD : S_PUT;
				end
				S_PUT: begin
					count_q <= count_q + PW'(1);
					rp_q <= row_q + RW'(1);
					state_q <= S_PTR_RD;
				end
				S_PTR_RD: state_q <= S_PTR_WR;
				S_PTR_WR: begin
					rp_q <= rp_q + RW'(1);
					state_q <= (32'(rp_q) == MAX_ROWS) ? S_DONE : S_PTR_RD;
				end
				S_DONE: begin
					status_q <= srsm_pkg::ST_INSERTED;
					vnow_q <= nv_q;
					ovalid_q <= 1'b1;
					rp_q <= '0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = ovalid_q;
	assign status = status_q;
	assign value_now = srsm_pkg::DATA_W'(vnow_q);
	assign entry_count = srsm_pkg::COUNT_W'(count_q);

endmodule

// ===== sv/srsm_checker.sv =====
// Port-level checks on the result channel and the entry count.
module srsm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [srsm_pkg::STATUS_W-1:0]   status,
	input logic [srsm_pkg::COUNT_W-1:0]    entry_count
);

	// A waiting result holds its status.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("result changed while stalled");

	// No item is taken while a result waits.
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open with pending result");

	// A cleared result reports an empty store.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == srsm_pkg::ST_CLEARED |-> entry_count == '0)
		else $error("clear left entries");

	// An insert raises the count.
	a_ins: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == srsm_pkg::ST_INSERTED |-> entry_count != '0)
		else $error("insert with zero count");

endmodule

bind sparse_row_sorted_merge_store_unit srsm_checker u_srsm_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .status(status),
	.entry_count(entry_count)
);
